>>> hdl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and constants for the session bit receiver.
// ----------------------------------------------------------------------------
package sbr_pkg;

	localparam int unsigned IdWidth   = 22;
	localparam int unsigned ByteBits  = 8;
	localparam int unsigned CountBits = $clog2(ByteBits);

	localparam logic [CountBits-1:0] CountLast = CountBits'(ByteBits - 1);
	localparam logic [ByteBits-1:0]  NulByte   = '0;
	localparam logic [IdWidth-1:0]   NoOwner   = '0;

	// reply codes
	localparam logic ReplyAck  = 1'b0;
	localparam logic ReplyDone = 1'b1;
	localparam logic ReplyBusy = 1'b1;

	// signal kinds
	localparam logic KindOne  = 1'b1;

	typedef struct packed {
		logic [IdWidth-1:0] sender_id;
		logic               signal_kind;
	} event_t;

	typedef struct packed {
		logic                reply_valid;
		logic [IdWidth-1:0]  reply_target;
		logic                reply_kind;
		logic                char_valid;
		logic [ByteBits-1:0] char_value;
		logic                message_done;
		logic                session_opened;
	} result_t;

	// pipeline flow control between the stages
	typedef struct packed {
		logic advance;
	} flow_t;

endpackage

>>> hdl/sbr_event_if.sv
// ----------------------------------------------------------------------------
// sbr_event_if
// Valid/ready channel carrying one signal event per item.
// ----------------------------------------------------------------------------
interface sbr_event_if;
	logic                          valid;
	logic                          ready;
	logic [sbr_pkg::IdWidth-1:0]   sender_id;
	logic                          signal_kind;

	modport source (output valid, output sender_id, output signal_kind, input ready);
	modport sink   (input valid, input sender_id, input signal_kind, output ready);
endinterface

>>> hdl/sbr_result_if.sv
// ----------------------------------------------------------------------------
// sbr_result_if
// Valid/ready channel carrying one receiver result per item.
// ----------------------------------------------------------------------------
interface sbr_result_if;
	logic                           valid;
	logic                           ready;
	logic                           reply_valid;
	logic [sbr_pkg::IdWidth-1:0]    reply_target;
	logic                           reply_kind;
	logic                           char_valid;
	logic [sbr_pkg::ByteBits-1:0]   char_value;
	logic                           message_done;
	logic                           session_opened;

	modport source (
		output valid, output reply_valid, output reply_target, output reply_kind,
		output char_valid, output char_value, output message_done,
		output session_opened, input ready
	);
	modport sink (
		input valid, input reply_valid, input reply_target, input reply_kind,
		input char_valid, input char_value, input message_done,
		input session_opened, output ready
	);
endinterface

>>> hdl/sbr_in_stage.sv
// ----------------------------------------------------------------------------
// sbr_in_stage
// Input register: captures one event item and holds it until processed.
// ----------------------------------------------------------------------------
module sbr_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	sbr_event_if.sink            events,
	input  sbr_pkg::flow_t       flow,
	output logic                 valid_s1,
	output sbr_pkg::event_t      evt_s1
);

	logic take;

	assign events.ready = !valid_s1 || flow.advance;
	assign take         = events.valid && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (flow.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			evt_s1.sender_id   <= events.sender_id;
			evt_s1.signal_kind <= events.signal_kind;
		end
	end

endmodule

>>> hdl/sbr_session.sv
// ----------------------------------------------------------------------------
// sbr_session
// Session state and per-event decode: open, refuse, shift bits, close.
// ----------------------------------------------------------------------------
module sbr_session (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbr_pkg::flow_t       flow,
	input  sbr_pkg::event_t      evt_s1,
	output sbr_pkg::result_t     res
);

	logic [sbr_pkg::IdWidth-1:0]   owner_q, owner_d;
	logic [sbr_pkg::ByteBits-1:0]  shift_q, shift_d, shifted;
	logic [sbr_pkg::CountBits-1:0] count_q, count_d;

	assign shifted = {shift_q[sbr_pkg::ByteBits-2:0], evt_s1.signal_kind};

	always_comb begin
		owner_d = owner_q;
		shift_d = shift_q;
		count_d = count_q;
		res     = '0;

		if (evt_s1.sender_id == sbr_pkg::NoOwner) begin
			// unknown sender, dropped silently
		end else if (owner_q == sbr_pkg::NoOwner) begin
			if (evt_s1.signal_kind == sbr_pkg::KindOne) begin
				owner_d            = evt_s1.sender_id;
				res.session_opened = 1'b1;
				res.reply_valid    = 1'b1;
				res.reply_target   = evt_s1.sender_id;
				res.reply_kind     = sbr_pkg::ReplyAck;
			end
		end else if (evt_s1.sender_id != owner_q) begin
			res.reply_valid  = 1'b1;
			res.reply_target = evt_s1.sender_id;
			res.reply_kind   = sbr_pkg::ReplyBusy;
		end else begin
			shift_d          = shifted;
			res.reply_valid  = 1'b1;
			res.reply_target = owner_q;
			res.reply_kind   = sbr_pkg::ReplyAck;
			if (count_q == sbr_pkg::CountLast) begin
				count_d = '0;
				if (shifted == sbr_pkg::NulByte) begin
					// terminating zero byte ends the session
					res.reply_kind   = sbr_pkg::ReplyDone;
					res.message_done = 1'b1;
					owner_d          = sbr_pkg::NoOwner;
				end else begin
					res.char_valid = 1'b1;
					res.char_value = shifted;
					shift_d        = '0;
				end
			end else begin
				count_d = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= sbr_pkg::NoOwner;
			shift_q <= '0;
			count_q <= '0;
		end else if (flow.advance) begin
			owner_q <= owner_d;
			shift_q <= shift_d;
			count_q <= count_d;
		end
	end

endmodule

>>> hdl/sbr_out_stage.sv
// ----------------------------------------------------------------------------
// sbr_out_stage
// Result register: holds one finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module sbr_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sbr_pkg::flow_t       flow,
	input  sbr_pkg::result_t     res,
	output logic                 out_free,
	sbr_result_if.source         replies
);

	logic             valid_s2;
	sbr_pkg::result_t res_s2;

	// free when empty or when the held item leaves this cycle
	assign out_free = !valid_s2 || replies.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (flow.advance) begin
			valid_s2 <= 1'b1;
		end else if (replies.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.advance) begin
			res_s2 <= res;
		end
	end

	assign replies.valid          = valid_s2;
	assign replies.reply_valid    = res_s2.reply_valid;
	assign replies.reply_target   = res_s2.reply_target;
	assign replies.reply_kind     = res_s2.reply_kind;
	assign replies.char_valid     = res_s2.char_valid;
	assign replies.char_value     = res_s2.char_value;
	assign replies.message_done   = res_s2.message_done;
	assign replies.session_opened = res_s2.session_opened;

endmodule

>>> hdl/session_bit_receiver.sv
// ----------------------------------------------------------------------------
// session_bit_receiver
// Serial bit receiver with a single-owner session and per-bit replies.
// ----------------------------------------------------------------------------
// Usage:
//   events  : sink channel, one item per signal event (sender_id, signal_kind).
//   replies : source channel, exactly one result item per event item, in order.
//   Each event passes an input register, one step of decode and state update,
//   and a result register. One event per cycle is sustained while replies.ready
//   stays high; the session state is updated in the same cycle the event moves
//   into the result register, so back-to-back events see each other's effect.
//   When the receiver holds ready low the result register keeps its item, the
//   input register may still take one more event, and events.ready then drops
//   until the result is taken; ready is combinational from replies.ready.
//   Reset (arst_n low) closes any open session, clears the partial byte and
//   bit count, and empties both registers.
// ----------------------------------------------------------------------------
module session_bit_receiver (
	input  logic        clk,
	input  logic        arst_n,
	sbr_event_if.sink   events,
	sbr_result_if.source replies
);

	logic             valid_s1;
	sbr_pkg::event_t  evt_s1;
	sbr_pkg::result_t res;
	sbr_pkg::flow_t   flow;
	logic             out_free;

	assign flow.advance  = valid_s1 && out_free;

	sbr_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events),
		.flow    (flow),
		.valid_s1(valid_s1),
		.evt_s1  (evt_s1)
	);

	sbr_session u_session (
		.clk   (clk),
		.arst_n(arst_n),
		.flow  (flow),
		.evt_s1(evt_s1),
		.res   (res)
	);

	sbr_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.flow    (flow),
		.res     (res),
		.out_free(out_free),
		.replies (replies)
	);

endmodule

>>> hdl/sbr_checker.sv
// ----------------------------------------------------------------------------
// sbr_checker
// Port-level checks on the result channel of the session bit receiver.
// ----------------------------------------------------------------------------
module sbr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           reply_valid,
	input logic [sbr_pkg::IdWidth-1:0]    reply_target,
	input logic                           reply_kind,
	input logic                           char_valid,
	input logic [sbr_pkg::ByteBits-1:0]   char_value,
	input logic                           message_done,
	input logic                           session_opened
);

	// no reply means empty target and kind
	a_quiet_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_valid |-> reply_target == '0 && reply_kind == 1'b0)
		else $error("silent item carries a reply target or kind");

	// a delivered byte is never the terminator and never closes the session
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> char_value != '0 && !message_done
		&& reply_valid && reply_kind == 1'b0)
		else $error("emitted byte is zero or combined with session end");

	// session end is always signalled to the owner with a done reply
	a_done_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> reply_valid && reply_kind == 1'b1
		&& !session_opened)
		else $error("session end without done reply");

	// opening acknowledges with continue and emits nothing
	a_open_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && session_opened |-> reply_valid && reply_kind == 1'b0
		&& !char_valid && reply_target != '0)
		else $error("session open without plain acknowledgement");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reply_target)
		&& $stable(char_value))
		else $error("result item changed while stalled");

endmodule

bind session_bit_receiver sbr_checker u_sbr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (replies.valid),
	.out_ready     (replies.ready),
	.reply_valid   (replies.reply_valid),
	.reply_target  (replies.reply_target),
	.reply_kind    (replies.reply_kind),
	.char_valid    (replies.char_valid),
	.char_value    (replies.char_value),
	.message_done  (replies.message_done),
	.session_opened(replies.session_opened)
);

>>> bench/sbr_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbr_reply_checker
// Watches the event and result channels of the session bit receiver, keeps
// its own copy of the session state, works out the reply that each event
// should give, and compares every result with the oldest reply still due.
// ----------------------------------------------------------------------------
module sbr_reply_checker (
	input  logic  clk,
	input  logic  arst_n,
	sbr_event_if  ev,
	sbr_result_if rs,
	output int    fail_count,
	output int    pending_count
);

	logic [sbr_pkg::IdWidth-1:0]   owner      = sbr_pkg::NoOwner;
	logic [sbr_pkg::ByteBits-1:0]  shift_byte = '0;
	logic [sbr_pkg::CountBits-1:0] bit_count  = '0;
	sbr_pkg::result_t              replies_due[$];
	int                            errors  = 0;
	int                            pending = 0;

	assign fail_count    = errors;
	assign pending_count = pending;

	function automatic sbr_pkg::result_t decode_event(input logic [sbr_pkg::IdWidth-1:0] id,
		input logic kind);
		sbr_pkg::result_t             r;
		logic [sbr_pkg::ByteBits-1:0] next_byte;
		r = '0;
		if (id == sbr_pkg::NoOwner) begin
			// unknown sender, nothing happens
		end else if (owner == sbr_pkg::NoOwner) begin
			if (kind == sbr_pkg::KindOne) begin
				owner            = id;
				r.session_opened = 1'b1;
				r.reply_valid    = 1'b1;
				r.reply_target   = id;
				r.reply_kind     = sbr_pkg::ReplyAck;
			end
		end else if (id != owner) begin
			r.reply_valid  = 1'b1;
			r.reply_target = id;
			r.reply_kind   = sbr_pkg::ReplyBusy;
		end else begin
			next_byte      = {shift_byte[sbr_pkg::ByteBits-2:0], kind};
			r.reply_valid  = 1'b1;
			r.reply_target = owner;
			r.reply_kind   = sbr_pkg::ReplyAck;
			if (bit_count == sbr_pkg::CountLast) begin
				bit_count  = '0;
				shift_byte = '0;
				if (next_byte == sbr_pkg::NulByte) begin
					r.reply_kind   = sbr_pkg::ReplyDone;
					r.message_done = 1'b1;
					owner          = sbr_pkg::NoOwner;
				end else begin
					r.char_valid = 1'b1;
					r.char_value = next_byte;
				end
			end else begin
				bit_count  = bit_count + 1'b1;
				shift_byte = next_byte;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		sbr_pkg::result_t want;
		if (arst_n) begin
			if (rs.valid && rs.ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result item with no event waiting: target %0h", rs.reply_target);
				end else begin
					want = replies_due.pop_front();
					check_field("reply_valid", 32'(want.reply_valid), 32'(rs.reply_valid));
					check_field("reply_target", 32'(want.reply_target), 32'(rs.reply_target));
					check_field("reply_kind", 32'(want.reply_kind), 32'(rs.reply_kind));
					check_field("char_valid", 32'(want.char_valid), 32'(rs.char_valid));
					check_field("char_value", 32'(want.char_value), 32'(rs.char_value));
					check_field("message_done", 32'(want.message_done), 32'(rs.message_done));
					check_field("session_opened", 32'(want.session_opened),
						32'(rs.session_opened));
				end
			end
			if (ev.valid && ev.ready)
				replies_due.push_back(decode_event(ev.sender_id, ev.signal_kind));
			pending <= replies_due.size();
		end
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the session bit receiver bench: drives events and result back
// pressure, runs one directed session and then random ones with stray
// senders and abandoned bytes, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

	typedef logic [sbr_pkg::IdWidth-1:0] id_t;

	localparam int ItemCount   = 1050;
	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 20;

	logic clk;
	logic arst_n;
	int   send_idle    = 11;
	int   recv_idle    = 76;
	int   items_sent   = 0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pending_count;

	sbr_event_if  ev_ch();
	sbr_result_if rs_ch();

	session_bit_receiver i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_ch),
		.replies (rs_ch)
	);

	sbr_reply_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.ev            (ev_ch),
		.rs            (rs_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rs_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	// ends the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((ev_ch.valid && ev_ch.ready) || (rs_ch.valid && rs_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic id_t rand_id();
		id_t id;
		case ($urandom_range(9))
			0: id = '1;
			1: id = id_t'(1);
			default: id = id_t'($urandom);
		endcase
		if (id == sbr_pkg::NoOwner)
			id = id_t'(1);
		return id;
	endfunction

	task automatic send_event(input id_t id, input logic kind);
		while ($urandom_range(99) < send_idle) begin
			ev_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ev_ch.valid       <= 1'b1;
		ev_ch.sender_id   <= id;
		ev_ch.signal_kind <= kind;
		@(posedge clk);
		while (!ev_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic stray_events(input id_t owner);
		id_t id;
		int  pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			do id = rand_id(); while (id == owner);
			send_event(id, 1'($urandom));
		end else if (pick < 12) begin
			send_event(sbr_pkg::NoOwner, 1'($urandom));
		end
	endtask

	task automatic send_byte(input id_t owner, input logic [sbr_pkg::ByteBits-1:0] data);
		for (int b = sbr_pkg::ByteBits - 1; b >= 0; b--) begin
			stray_events(owner);
			send_event(owner, data[b]);
		end
	endtask

	task automatic run_session();
		id_t owner;
		int  n_bytes;
		int  cut;
		owner = rand_id();
		if ($urandom_range(9) == 0)
			send_event(rand_id(), 1'b0);
		send_event(owner, sbr_pkg::KindOne);
		n_bytes = $urandom_range(3);
		cut     = ($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1;
		for (int i = 0; i < n_bytes; i++)
			send_byte(owner, 8'($urandom_range(255, 1)));
		if (cut >= 0) begin
			// abandoned byte, then enough zeros that the session must close
			for (int b = 0; b < cut; b++)
				send_event(owner, 1'($urandom));
			for (int b = 0; b < 2 * sbr_pkg::ByteBits; b++)
				send_event(owner, 1'b0);
		end else begin
			send_byte(owner, sbr_pkg::NulByte);
		end
	endtask

	task automatic wait_replies();
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n            <= 1'b0;
		ev_ch.valid       <= 1'b0;
		ev_ch.sender_id   <= '0;
		ev_ch.signal_kind <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle: kind zero and unknown sender are ignored
		send_event('1, 1'b0);
		send_event(sbr_pkg::NoOwner, sbr_pkg::KindOne);
		// open with the widest id, then a foreign sender and an unknown one
		send_event('1, sbr_pkg::KindOne);
		send_event(id_t'(1), 1'b0);
		send_event(id_t'(1), sbr_pkg::KindOne);
		send_event(sbr_pkg::NoOwner, sbr_pkg::KindOne);
		for (int b = sbr_pkg::ByteBits - 1; b >= 0; b--)
			send_event('1, 1'b1);
		for (int b = sbr_pkg::ByteBits - 1; b >= 0; b--)
			send_event('1, 1'b0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 11;
					recv_idle = 76;
				end
				1: begin
					send_idle = 76;
					recv_idle = 11;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			while (items_sent < (phase + 1) * ItemCount / 3)
				run_session();
			// hold off until every reply is back
			ev_ch.valid <= 1'b0;
			wait_replies();
		end

		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> session_bit_receiver.f
hdl/sbr_pkg.sv
hdl/sbr_event_if.sv
hdl/sbr_result_if.sv
hdl/sbr_in_stage.sv
hdl/sbr_session.sv
hdl/sbr_out_stage.sv
hdl/session_bit_receiver.sv
hdl/sbr_checker.sv
bench/sbr_reply_checker.sv
bench/tb.sv
